// File: design/sdtw_pkg.sv
// shared types and constants for the signed decimal tile writer
// used by sdtw_ctrl, sdtw_datapath and signed_decimal_tile_writer
package sdtw_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int VALUE_BITS = 32;

    localparam int NUMBER_W = 32;
    localparam int BCD_W    = 4 * MAX_DIGITS;
    localparam int STEP_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIGIT_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [5:0] TILE_DIGIT_BASE = 6'h01;
    localparam logic [5:0] TILE_MINUS      = 6'h3B;

    typedef struct packed {
        logic [4:0]                 start_col;
        logic [4:0]                 tile_row;
        logic signed [NUMBER_W-1:0] number;
        logic                       to_window;
    } in_item_t;

    typedef struct packed {
        logic [5:0] column;
        logic [4:0] row_out;
        logic       window_out;
        logic [5:0] tile_code;
        logic       last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic step_last;
        logic digit_zero;
        logic ptr_zero;
        logic negative;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage

// File: design/signed_decimal_tile_writer.sv
// top level of the signed decimal tile writer
// depends on sdtw_pkg, sdtw_ctrl and sdtw_datapath

// Takes one signed number per start transaction (start high while busy is
// low) and writes its decimal form as a run of tiles, left to right: a
// minus tile 59 for negative values, then digits as tiles 1 to 10, with
// leading zeros dropped and zero shown as a single tile 1. Each tile is
// presented on result for exactly one cycle with valid high and cannot be
// held off. A number goes through a load, the double-dabble shift loop at
// one bit per cycle, a skip of the leading zero digits, an optional minus
// tile and then the digits at one tile per cycle, after which busy drops.
// The last tile is on result in the first cycle with busy low, and a new
// start may be accepted in that cycle.
module signed_decimal_tile_writer
    import sdtw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      valid,
    output out_item_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sdtw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sdtw_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .valid  (valid),
        .result (result)
    );

endmodule

// File: design/sdtw_ctrl.sv
// sequencing state machine for the signed decimal tile writer
// depends on sdtw_pkg; drives commands into sdtw_datapath
module sdtw_ctrl
    import sdtw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (status.step_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, always keep the units digit
                if (status.digit_zero && !status.ptr_zero)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.negative)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                if (status.ptr_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: design/sdtw_datapath.sv
// double-dabble converter, digit pointer and tile output register
// depends on sdtw_pkg; commanded by sdtw_ctrl
module sdtw_datapath
    import sdtw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       valid,
    output out_item_t  result
);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [STEP_W-1:0]     step_cnt_reg;
    logic [DIGIT_W-1:0]    ptr_reg;
    logic                  neg_reg;
    logic [5:0]            col_reg;
    logic [4:0]            row_reg;
    logic                  win_reg;
    logic                  valid_reg;
    out_item_t             result_reg;

    logic [63:0]           num_wide;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            cur_digit;

    assign num_wide = 64'(unsigned'(item.number));
    assign raw      = num_wide[VALUE_BITS-1:0];
    // most negative value negates to 2^(VALUE_BITS-1) as an unsigned magnitude
    assign mag      = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

    // add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
        bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
        bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
    end

    assign cur_digit = bcd_reg[ptr_reg*4 +: 4];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg      <= mag;
            bcd_reg      <= '0;
            step_cnt_reg <= '0;
            ptr_reg      <= DIGIT_W'(MAX_DIGITS - 1);
            neg_reg      <= raw[VALUE_BITS-1];
            col_reg      <= {1'b0, item.start_col};
            row_reg      <= item.tile_row;
            win_reg      <= item.to_window;
        end
        else
        begin
            if (cmd.step)
            begin
                bin_reg      <= bin_next;
                bcd_reg      <= bcd_next;
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
            if ((cmd.skip || cmd.emit_digit) && (ptr_reg != '0))
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end
            if (cmd.emit_sign || cmd.emit_digit)
            begin
                col_reg <= col_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign || cmd.emit_digit)
        begin
            result_reg.column     <= col_reg;
            result_reg.row_out    <= row_reg;
            result_reg.window_out <= win_reg;
            result_reg.tile_code  <= cmd.emit_sign ? TILE_MINUS
                                                   : TILE_DIGIT_BASE + {2'b00, cur_digit};
            result_reg.last       <= cmd.emit_digit && (ptr_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit_sign || cmd.emit_digit;
        end
    end

    assign status.step_last  = (step_cnt_reg == STEP_W'(VALUE_BITS - 1));
    assign status.digit_zero = (cur_digit == 4'd0);
    assign status.ptr_zero   = (ptr_reg == '0);
    assign status.negative   = neg_reg;

    assign valid  = valid_reg;
    assign result = result_reg;

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.skip, cmd.emit_sign, cmd.emit_digit}))
        else $error("more than one datapath command at once");

    a_tile_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (result.tile_code == TILE_MINUS) ||
                  ((result.tile_code >= TILE_DIGIT_BASE) &&
                   (result.tile_code <= TILE_DIGIT_BASE + 6'd9)))
        else $error("tile code outside digit and minus range");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (result.tile_code == TILE_MINUS) |-> !result.last)
        else $error("minus tile marked as last of run");

    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sign |=> cmd.emit_digit)
        else $error("minus tile not followed by a digit");

endmodule

// File: tb/sv/sdtw_tile_checker.sv
// checker for the signed decimal tile writer: predicts the tile run of each
// accepted number and compares it with the tiles the block writes
// depends on sdtw_pkg
module sdtw_tile_checker
    import sdtw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_item_t  item,
    input  logic      valid,
    input  out_item_t result,
    input  logic      wrap_up,
    output int        pending,
    output int        tiles_checked,
    output int        fail_count
);

    out_item_t expected_tiles[$];

    initial
    begin
        pending       = 0;
        tiles_checked = 0;
        fail_count    = 0;
    end

    task automatic flag_error(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fail_count++;
    endtask

    // decimal rendering of one number, most significant digit first
    function automatic void render_tiles(input in_item_t req);
        logic [VALUE_BITS-1:0] raw;
        logic [VALUE_BITS-1:0] magnitude;
        longint unsigned       rest;
        logic [3:0]            digits [MAX_DIGITS];
        int                    ndigits;
        int                    total;
        bit                    negative;
        out_item_t             tile;
        raw       = req.number[VALUE_BITS-1:0];
        negative  = raw[VALUE_BITS-1];
        // the most negative value comes out as its full unsigned magnitude
        magnitude = negative ? ~raw + 1'b1 : raw;
        rest      = magnitude;
        ndigits   = 0;
        if (rest == 0)
        begin
            digits[0] = 4'd0;
            ndigits   = 1;
        end
        else
        begin
            while (rest != 0 && ndigits < MAX_DIGITS)
            begin
                digits[ndigits] = 4'(rest % 10);
                rest            = rest / 10;
                ndigits++;
            end
        end
        total = ndigits + (negative ? 1 : 0);
        for (int pos = 0; pos < total; pos++)
        begin
            tile.column     = 6'(req.start_col + pos);
            tile.row_out    = req.tile_row;
            tile.window_out = req.to_window;
            if (negative && pos == 0)
                tile.tile_code = TILE_MINUS;
            else
                tile.tile_code = TILE_DIGIT_BASE + digits[total - 1 - pos];
            tile.last = (pos == total - 1);
            expected_tiles.push_back(tile);
        end
    endfunction

    task automatic check_tile(input out_item_t got);
        out_item_t want;
        if (expected_tiles.size() == 0)
        begin
            flag_error($sformatf("tile with nothing expected: col %0d code %0d",
                                 got.column, got.tile_code));
            return;
        end
        want = expected_tiles.pop_front();
        tiles_checked++;
        if (got.column !== want.column)
            flag_error($sformatf("column %0d, expected %0d", got.column, want.column));
        if (got.row_out !== want.row_out)
            flag_error($sformatf("row_out %0d, expected %0d", got.row_out, want.row_out));
        if (got.window_out !== want.window_out)
            flag_error($sformatf("window_out %0b, expected %0b",
                                 got.window_out, want.window_out));
        if (got.tile_code !== want.tile_code)
            flag_error($sformatf("tile_code %0d, expected %0d at column %0d",
                                 got.tile_code, want.tile_code, want.column));
        if (got.last !== want.last)
            flag_error($sformatf("last %0b, expected %0b at column %0d",
                                 got.last, want.last, want.column));
    endtask

    // a tile leaving and a new transaction can share one edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid)
                check_tile(result);
            if (start && !busy)
                render_tiles(item);
            pending = expected_tiles.size();
        end
    end

    always @(posedge wrap_up)
    begin
        if (expected_tiles.size() != 0)
            flag_error($sformatf("%0d expected tiles never came out",
                                 expected_tiles.size()));
    end

endmodule

// File: tb/sv/signed_decimal_tile_writer_test.sv
// top of the signed decimal tile writer testbench: clock, reset, number
// stimulus with random idle gaps, and the verdict
// depends on sdtw_pkg, sdtw_tile_checker and signed_decimal_tile_writer
module signed_decimal_tile_writer_test;
    import sdtw_pkg::*;

    localparam int RANDOM_NUMBERS = 150;
    localparam int CORNER_COUNT   = 18;
    localparam logic [31:0] CORNER_VALUES [CORNER_COUNT] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
        -32'sd100, 32'd999999999, 32'd1000000000, -32'sd1000000000, 32'd123456789,
        -32'sd987654321, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000
    };

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    in_item_t  item    = '0;
    logic      wrap_up = 1'b0;
    logic      busy;
    logic      valid;
    out_item_t result;

    int pending;
    int tiles_checked;
    int fail_count;
    int numbers_sent   = 0;
    int negatives_sent = 0;
    bit no_idle        = 1'b0;

    always #2 clk = ~clk;

    signed_decimal_tile_writer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .valid  (valid),
        .result (result)
    );

    sdtw_tile_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .valid         (valid),
        .result        (result),
        .wrap_up       (wrap_up),
        .pending       (pending),
        .tiles_checked (tiles_checked),
        .fail_count    (fail_count)
    );

    function automatic in_item_t make_item(input int col, input int row,
                                           input logic [31:0] value, input int win);
        in_item_t req;
        req.start_col = 5'(col);
        req.tile_row  = 5'(row);
        req.number    = value;
        req.to_window = 1'(win);
        return req;
    endfunction

    // spread the random numbers over digit counts, signs and decade borders
    function automatic logic [31:0] pick_number();
        longint decade;
        longint value;
        decade = 1;
        case ($urandom_range(0, 5))
            0:
            begin
                repeat ($urandom_range(0, 9)) decade *= 10;
                value = decade + $urandom_range(0, 2) - 1;
            end
            1:
                value = $urandom_range(0, 20);
            2:
                value = $urandom >> $urandom_range(0, 31);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0001;
                    default: return 32'd0;
                endcase
            end
            default:
                return $urandom;
        endcase
        if ($urandom_range(0, 1))
            value = -value;
        return 32'(value);
    endfunction

    // called right after a rising edge; returns right after one
    task automatic send_number(input in_item_t req);
        int gap;
        start <= 1'b1;
        item  <= req;
        do @(posedge clk); while (busy);
        numbers_sent++;
        if (req.number < 0)
            negatives_sent++;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            start <= 1'b0;
            // sometimes let the gap start only once the block has gone idle
            if ($urandom_range(0, 1))
                do @(posedge clk); while (busy);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_tiles();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < CORNER_COUNT; i++)
            send_number(make_item(i >= 15 ? 31 : (i == 0 ? 0 : $urandom_range(0, 31)),
                                  (i % 2) ? 31 : 0, CORNER_VALUES[i], i % 2));
        drain_tiles();

        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            if (i % 16 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_number(make_item($urandom_range(0, 31), $urandom_range(0, 31),
                                  pick_number(), $urandom_range(0, 1)));
            if ($urandom_range(0, 24) == 0)
                drain_tiles();
        end

        drain_tiles();
        repeat (50) @(posedge clk);
        wrap_up <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        $display("ran %0d numbers (%0d negative, corners and decade borders included)",
                 numbers_sent, negatives_sent);
        $display("compared %0d tiles against the predicted runs", tiles_checked);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #600000;
        $display("timeout: block stopped making progress");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
design/sdtw_pkg.sv
design/sdtw_ctrl.sv
design/sdtw_datapath.sv
design/signed_decimal_tile_writer.sv
tb/sv/sdtw_tile_checker.sv
tb/sv/signed_decimal_tile_writer_test.sv
